// ----- hdl/ytv_pkg.sv -----
// ---------------------------------------------------------------------------
// ytv_pkg: shared types and constants for the yaw torque vectoring block
// Register indexes, field widths, interpolation table and unit types.
// ---------------------------------------------------------------------------
package ytv_pkg;

  localparam int TABLE_SIZE = 8;
  localparam int ROM_SLOTS  = 16;
  localparam int IDX_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIVD_W     = 36;
  localparam int DIVS_W     = 25;
  localparam int OPND_W     = 33;
  localparam int PROD_W     = 66;
  localparam int GAIN_W     = 25;

  localparam logic [CFG_IDX_W-1:0] REG_FRICTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KU       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHEELB   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MLIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TSAMPLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MINSPD   = 3'd6;

  localparam logic [15:0] SPD_LOW  = 16'd768;
  localparam logic [15:0] SPD_HIGH = 16'(768 + 1024 * (TABLE_SIZE - 1));

  typedef struct packed {
    logic busy;
    logic done;
  } ytv_div_stat_t;

  function automatic logic signed [GAIN_W-1:0] kp_rom(input logic [IDX_W-1:0] idx);
    logic signed [GAIN_W-1:0] g;
    case (idx)
      4'd0: g = -25'sd35837;
      4'd1: g = 25'sd142021;
      4'd2: g = 25'sd181668;
      4'd3: g = 25'sd200169;
      4'd4: g = 25'sd210881;
      4'd5: g = 25'sd217867;
      4'd6: g = 25'sd222783;
      4'd7: g = 25'sd226430;
      default: g = '0;
    endcase
    return g;
  endfunction

  function automatic logic signed [GAIN_W-1:0] ki_rom(input logic [IDX_W-1:0] idx);
    logic signed [GAIN_W-1:0] g;
    case (idx)
      4'd0: g = -25'sd6562203;
      4'd1: g = 25'sd4940271;
      4'd2: g = 25'sd5943326;
      4'd3: g = 25'sd6775119;
      4'd4: g = 25'sd7362469;
      4'd5: g = 25'sd7787318;
      4'd6: g = 25'sd8106065;
      4'd7: g = 25'sd8353113;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ----- hdl/ytv_ifs.sv -----
// ---------------------------------------------------------------------------
// ytv interfaces: channel bundles
// Input, result and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
interface ytv_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] wheel_angle;
  logic        [15:0] speed;
  logic signed [15:0] yaw_rate;
  logic signed [15:0] drive_request;
  modport source (output valid, wheel_angle, speed, yaw_rate, drive_request, input ready);
  modport sink   (input valid, wheel_angle, speed, yaw_rate, drive_request, output ready);
endinterface

interface ytv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_cmd;
  logic signed [15:0] right_cmd;
  logic               moment_clamped;
  modport source (output valid, left_cmd, right_cmd, moment_clamped, input ready);
  modport sink   (input valid, left_cmd, right_cmd, moment_clamped, output ready);
endinterface

interface ytv_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/ytv_mul.sv -----
// ---------------------------------------------------------------------------
// ytv_mul: shared signed multiplier
// One signed product per cycle, result registered.
// ---------------------------------------------------------------------------
module ytv_mul (
  input  logic                                clk,
  input  logic signed [ytv_pkg::OPND_W-1:0]   opa,
  input  logic signed [ytv_pkg::OPND_W-1:0]   opb,
  output logic signed [ytv_pkg::PROD_W-1:0]   prod_r
);
  import ytv_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(opa) * PROD_W'(opb);
  end
endmodule

// ----- hdl/ytv_div.sv -----
// ---------------------------------------------------------------------------
// ytv_div: serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ytv_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ytv_pkg::DIVD_W-1:0]    dividend,
  input  logic [ytv_pkg::DIVS_W-1:0]    divisor,
  output logic [ytv_pkg::DIVD_W-1:0]    quo_r,
  output ytv_pkg::ytv_div_stat_t        stat
);
  import ytv_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dsr_r;
  logic              done_r;
  logic [DIVS_W:0]   shifted;
  logic              ge;

  assign shifted = {rem_r, quo_r[DIVD_W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign stat.busy = cnt_r != '0;
  assign stat.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(DIVD_W);
        rem_r <= '0;
        dsr_r <= divisor;
        quo_r <= dividend;
      end else if (cnt_r != '0) begin
        // shift in next dividend bit, subtract when it fits
        rem_r <= ge ? DIVS_W'(shifted - {1'b0, dsr_r}) : DIVS_W'(shifted);
        quo_r <= {quo_r[DIVD_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) done_r <= 1'b1;
      end
    end
  end
endmodule

// ----- hdl/yaw_torque_vectoring_pi.sv -----
// ---------------------------------------------------------------------------
// yaw_torque_vectoring_pi: gain-scheduled PI yaw-rate torque vectoring
// Sequencer around one shared multiplier and one serial divider.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch   : one beat per control tick (steer, speed, yaw rate, demand).
//   out_ch  : one beat per input beat (left/right torque, clamp flag).
//   cfg_ch  : register writes, always ready; write only while idle.
// Steps: the two serial divisions (target yaw rate and friction limit)
//   run one after the other on the serial divider; most remaining steps
//   are single multiplies on the shared unit.
// Flow: in_ch.ready is high only while the sequencer is idle, so a new
//   beat waits until the previous one has been computed. A new beat is
//   taken while the previous result still waits on out_ch.
// Stall: a result held by the receiver stays in the output register; a
//   finished computation waits in its last step until the register frees.
// Reset: synchronous, active low; registers return to default values and
//   the yaw integrator clears. No clearing pass.
// ---------------------------------------------------------------------------
module yaw_torque_vectoring_pi (
  input  logic clk,
  input  logic rst_n,
  ytv_in_if.sink    in_ch,
  ytv_out_if.source out_ch,
  ytv_cfg_if.sink   cfg_ch
);
  import ytv_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_VV, ST_KU, ST_NUM, ST_DIV1, ST_DIV1W, ST_DIV2W, ST_ERR,
    ST_G1, ST_G2, ST_G3, ST_G4, ST_G5, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,
    ST_P6, ST_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic [15:0] friction_r, ku_r, wheelb_r, split_r, tsample_r, minspd_r;
  logic [14:0] mlimit_r;

  // latched item
  logic signed [15:0] steer_r, yaw_r, demand_r;
  logic        [15:0] spd_r, v_r;
  logic [IDX_W-1:0]   idx_r;
  logic [10:0]        frac_r;

  // working registers
  logic [DIVS_W-1:0]        den_r;
  logic                     neg_r;
  logic [DIVD_W-1:0]        tmag_r;
  logic signed [31:0]       err_r;
  logic signed [39:0]       gacc_r;
  logic signed [GAIN_W-1:0] kp_r, ki_r;
  logic signed [51:0]       u_r;
  logic signed [31:0]       integ_r;
  logic                     clamp_r;
  logic signed [20:0]       delta_r;

  logic signed [15:0] tl_r, tr_r;
  logic               mc_r, ovalid_r;

  // shared units
  logic signed [OPND_W-1:0] opa, opb;
  logic signed [PROD_W-1:0] prod_r;
  logic                     div_start;
  logic [DIVD_W-1:0]        div_dvd;
  logic [DIVS_W-1:0]        div_dsr;
  logic [DIVD_W-1:0]        div_q;
  ytv_div_stat_t            div_stat;

  function automatic logic [DIVS_W-1:0] div_sr_sel(input logic [DIVS_W-1:0] d,
                                                   input logic [15:0] v,
                                                   input state_t s);
    return (s == ST_DIV1) ? d : {{(DIVS_W-16){1'b0}}, v};
  endfunction

  assign div_dsr = div_sr_sel(den_r, v_r, state_r);

  ytv_mul u_mul (.clk(clk), .opa(opa), .opb(opb), .prod_r(prod_r));

  ytv_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dsr), .quo_r(div_q), .stat(div_stat)
  );

  // input-side speed handling
  logic [15:0] vc_in, off_in;
  logic [IDX_W-1:0] idx_in;
  always_comb begin
    vc_in  = (in_ch.speed < SPD_LOW) ? SPD_LOW :
             ((in_ch.speed > SPD_HIGH) ? SPD_HIGH : in_ch.speed);
    off_in = vc_in - SPD_LOW;
    idx_in = IDX_W'(off_in >> 10);
  end

  // product magnitude of steer*v for the target division
  logic [31:0] sv_mag;
  assign sv_mag = prod_r[PROD_W-1] ? 32'(-prod_r) : 32'(prod_r);

  // target clamp and error
  logic [DIVD_W-1:0] tclamp;
  logic signed [31:0] target_s;
  always_comb begin
    tclamp   = (tmag_r > div_q) ? div_q : tmag_r;
    target_s = neg_r ? -32'(tclamp) : 32'(tclamp);
  end

  // PI saturation
  logic signed [51:0] ulim_s;
  logic               over_hi, over_lo;
  logic signed [39:0] iacc;
  logic signed [31:0] iacc_sat;
  always_comb begin
    ulim_s  = $signed({25'd0, mlimit_r, 12'd0});
    over_hi = u_r > ulim_s;
    over_lo = u_r < -ulim_s;
    iacc    = 40'(integ_r) + 40'(prod_r >>> 8);
    if (iacc > 40'sd2147483647)       iacc_sat = 32'h7fffffff;
    else if (iacc < -40'sd2147483648) iacc_sat = 32'h80000000;
    else                              iacc_sat = 32'(iacc);
  end

  // output saturation
  logic signed [21:0] lsum, rsum;
  logic signed [15:0] lsat, rsat;
  always_comb begin
    lsum = 22'(demand_r) - 22'(delta_r);
    rsum = 22'(demand_r) + 22'(delta_r);
    lsat = (lsum > 22'sd32767) ? 16'sh7fff : ((lsum < -22'sd32768) ? 16'sh8000 : 16'(lsum));
    rsat = (rsum > 22'sd32767) ? 16'sh7fff : ((rsum < -22'sd32768) ? 16'sh8000 : 16'(rsum));
  end

  // operand and divider selection per step
  always_comb begin
    opa       = '0;
    opb       = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    unique case (state_r)
      ST_VV: begin
        opa = $signed({17'd0, v_r});
        opb = $signed({17'd0, v_r});
      end
      ST_KU: begin
        opa = $signed({17'd0, ku_r});
        opb = $signed({1'b0, prod_r[31:0]});
      end
      ST_NUM: begin
        opa = OPND_W'(steer_r);
        opb = $signed({17'd0, v_r});
      end
      ST_DIV1: begin
        div_start = 1'b1;
        div_dvd   = {sv_mag, 4'd0};
      end
      ST_DIV1W: begin
        div_start = div_stat.done;
        div_dvd   = {8'd0, friction_r, 12'd0};
      end
      ST_G1: begin
        opa = OPND_W'(kp_rom(idx_r));
        opb = $signed(OPND_W'(11'd1024 - frac_r));
      end
      ST_G2: begin
        opa = OPND_W'(kp_rom(idx_r + 1'b1));
        opb = $signed(OPND_W'(frac_r));
      end
      ST_G3: begin
        opa = OPND_W'(ki_rom(idx_r));
        opb = $signed(OPND_W'(11'd1024 - frac_r));
      end
      ST_G4: begin
        opa = OPND_W'(ki_rom(idx_r + 1'b1));
        opb = $signed(OPND_W'(frac_r));
      end
      ST_P1: begin
        opa = OPND_W'(kp_r);
        opb = OPND_W'(err_r);
      end
      ST_P2: begin
        opa = OPND_W'(ki_r);
        opb = OPND_W'(integ_r);
      end
      ST_P3: begin
        opa = $signed({17'd0, tsample_r});
        opb = OPND_W'(err_r);
      end
      ST_P5: begin
        opa = OPND_W'(u_r);
        opb = $signed({17'd0, split_r});
      end
      default: ;
    endcase
  end

  assign in_ch.ready         = state_r == ST_IDLE;
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = ovalid_r;
  assign out_ch.left_cmd     = tl_r;
  assign out_ch.right_cmd    = tr_r;
  assign out_ch.moment_clamped = mc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ovalid_r   <= 1'b0;
      integ_r    <= '0;
      friction_r <= 16'd4018;
      ku_r       <= 16'd1994;
      wheelb_r   <= 16'd6275;
      mlimit_r   <= 15'd12640;
      split_r    <= 16'd1207;
      tsample_r  <= 16'd1049;
      minspd_r   <= 16'd768;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_FRICTION: friction_r <= cfg_ch.data;
          REG_KU:       ku_r       <= cfg_ch.data;
          REG_WHEELB:   wheelb_r   <= cfg_ch.data;
          REG_MLIMIT:   mlimit_r   <= cfg_ch.data[14:0];
          REG_SPLIT:    split_r    <= cfg_ch.data;
          REG_TSAMPLE:  tsample_r  <= cfg_ch.data;
          REG_MINSPD:   minspd_r   <= cfg_ch.data;
          default: ;  // drop writes beyond the register list
        endcase
      end
      // the final step refills the output register itself
      if (ovalid_r && out_ch.ready && state_r != ST_DONE) ovalid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            steer_r  <= in_ch.wheel_angle;
            yaw_r    <= in_ch.yaw_rate;
            demand_r <= in_ch.drive_request;
            spd_r    <= in_ch.speed;
            v_r      <= (in_ch.speed == '0) ? 16'd1 : in_ch.speed;
            if (idx_in >= IDX_W'(TABLE_SIZE - 1)) begin
              idx_r  <= IDX_W'(TABLE_SIZE - 2);
              frac_r <= 11'd1024;
            end else begin
              idx_r  <= idx_in;
              frac_r <= {1'b0, off_in[9:0]};
            end
            state_r <= ST_VV;
          end
        end
        ST_VV:  state_r <= ST_KU;
        ST_KU:  state_r <= ST_NUM;
        ST_NUM: begin
          // denominator: wheelbase plus Ku*v^2 term, never zero
          den_r   <= ({9'd0, wheelb_r} + {1'b0, prod_r[47:24]} == '0) ? DIVS_W'(1) :
                     {9'd0, wheelb_r} + {1'b0, prod_r[47:24]};
          state_r <= ST_DIV1;
        end
        ST_DIV1: begin
          neg_r   <= prod_r[PROD_W-1];
          state_r <= ST_DIV1W;
        end
        ST_DIV1W: begin
          if (div_stat.done) begin
            tmag_r  <= div_q;
            state_r <= ST_DIV2W;
          end
        end
        ST_DIV2W: begin
          if (div_stat.done) state_r <= ST_ERR;
        end
        ST_ERR: begin
          err_r   <= target_s - 32'(yaw_r);
          state_r <= ST_G1;
        end
        ST_G1: state_r <= ST_G2;
        ST_G2: begin
          gacc_r  <= 40'(prod_r);
          state_r <= ST_G3;
        end
        ST_G3: begin
          kp_r    <= GAIN_W'((gacc_r + 40'(prod_r)) >>> 10);
          state_r <= ST_G4;
        end
        ST_G4: begin
          gacc_r  <= 40'(prod_r);
          state_r <= ST_G5;
        end
        ST_G5: begin
          ki_r    <= GAIN_W'((gacc_r + 40'(prod_r)) >>> 10);
          state_r <= ST_P1;
        end
        ST_P1: state_r <= ST_P2;
        ST_P2: begin
          u_r     <= 52'(prod_r);
          state_r <= ST_P3;
        end
        ST_P3: begin
          u_r     <= u_r + 52'(prod_r >>> 12);
          state_r <= ST_P4;
        end
        ST_P4: begin
          // clamp and freeze the integrator, else integrate with saturation
          if (over_hi) begin
            u_r     <= ulim_s;
            clamp_r <= 1'b1;
          end else if (over_lo) begin
            u_r     <= -ulim_s;
            clamp_r <= 1'b1;
          end else begin
            clamp_r <= 1'b0;
            integ_r <= iacc_sat;
          end
          state_r <= ST_P5;
        end
        ST_P5: state_r <= ST_P6;
        ST_P6: begin
          delta_r <= (spd_r < minspd_r) ? '0 :
                     21'((prod_r + PROD_W'(64'sd8388608)) >>> 24);
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!ovalid_r || out_ch.ready) begin
            tl_r     <= lsat;
            tr_r     <= rsat;
            mc_r     <= clamp_r;
            ovalid_r <= 1'b1;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("ready stayed high after an accepted input beat");

  a_freeze_on_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_P4 && (over_hi || over_lo)) |=> $stable(integ_r))
    else $error("integrator moved while the moment was clamped");

  a_low_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_P6 && spd_r < minspd_r) |=> delta_r == '0)
    else $error("torque offset applied below minimum speed");

  a_div_only_in_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == ST_DIV1W || state_r == ST_DIV2W))
    else $error("divider running outside its steps");
`endif

endmodule
